### design/cicc_pkg.sv
// ----------------------------------------------------------------------------
// cicc_pkg
// shared types, constants and helpers of the cell index converter
// ----------------------------------------------------------------------------
package cicc_pkg;

   // field widths
   localparam int ID_W    = 20;
   localparam int MOD_W   = 4;
   localparam int RC_W    = 9;
   localparam int XROW_W  = 8;
   localparam int XMOD_W  = 16;
   localparam int PMOD_W  = 18;
   localparam int MPROD_W = 22;
   localparam int RPROD_W = 18;
   localparam int HI_W    = 23;
   localparam int LO_W    = 19;
   localparam int SUM_W   = 24;
   localparam int TRIAL_W = 22;
   localparam int DATA_W  = 48;
   localparam int USER_W  = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;

   localparam logic [ID_W-1:0] ID_MAX = '1;

   // opcodes
   localparam logic OP_TO_REL = 1'b0;
   localparam logic OP_TO_ABS = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MODULE_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CRYSTAL_ROWS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CRYSTAL_COLS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PAD_ROWS     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PAD_COLS     = 3'd4;

   // register reset values
   localparam logic [MOD_W-1:0]  RST_MODULE_COUNT = 4'd5;
   localparam logic [XROW_W-1:0] RST_CRYSTAL_ROWS = 8'd64;
   localparam logic [XROW_W-1:0] RST_CRYSTAL_COLS = 8'd56;
   localparam logic [RC_W-1:0]   RST_PAD_ROWS     = 9'd128;
   localparam logic [RC_W-1:0]   RST_PAD_COLS     = 9'd60;
   localparam logic [XMOD_W-1:0] RST_XTAL_MOD     = 16'd3584;
   localparam logic [PMOD_W-1:0] RST_PAD_MOD      = 18'd7680;
   localparam logic [ID_W-1:0]   RST_XTAL_ALL     = 20'd17920;

   // divider chain: module quotient bits, then row quotient bits
   localparam int MOD_STEPS  = 5;
   localparam int ROW_STEPS  = 9;
   localparam int CELL_COUNT = MOD_STEPS + ROW_STEPS;
   localparam int SHIFT_W    = 4;

   typedef struct packed {
      logic [MOD_W-1:0]  module_count;
      logic [XROW_W-1:0] crystal_rows;
      logic [XROW_W-1:0] crystal_cols;
      logic [RC_W-1:0]   pad_rows;
      logic [RC_W-1:0]   pad_cols;
      logic [XMOD_W-1:0] xtal_mod;
      logic [PMOD_W-1:0] pad_mod;
      logic [ID_W-1:0]   xtal_all;
   } cicc_cfg_type;

   typedef struct packed {
      logic              opcode;
      logic [ID_W-1:0]   abs_id;
      logic [MOD_W-1:0]  module_req;
      logic              is_pad;
      logic [RC_W-1:0]   row;
      logic [RC_W-1:0]   column;
   } cicc_req_type;

   typedef struct packed {
      logic               opcode;
      logic               is_pad;
      logic               zero_id;
      logic               bad_rel;
      logic [ID_W-1:0]    z;
      logic [RC_W-1:0]    column;
      logic [MPROD_W-1:0] mprod;
      logic [RPROD_W-1:0] rprod;
   } cicc_mid_type;

   typedef struct packed {
      logic              opcode;
      logic              kind;
      logic              bad;
      logic [ID_W-1:0]   rem;
      logic [RC_W-1:0]   quot;
      logic [MOD_STEPS-1:0] quot_mod;
      logic [PMOD_W-1:0] per_mod;
      logic [RC_W-1:0]   cols;
      logic [HI_W-1:0]   sum_hi;
      logic [LO_W-1:0]   sum_lo;
   } cicc_item_type;

   typedef struct packed {
      logic [SHIFT_W-1:0] shift;
      logic               use_cols;
      logic               capture;
   } cicc_step_type;

   typedef struct packed {
      logic [ID_W-1:0]  abs_id_out;
      logic [MOD_W-1:0] module_out;
      logic             is_pad_out;
      logic [RC_W-1:0]  row_out;
      logic [RC_W-1:0]  column_out;
      logic             out_of_range;
   } cicc_rsp_type;

   // control of divider cell idx: module phase shifts 4..0, row phase 8..0
   function automatic cicc_step_type cell_step(input int idx);
      cicc_step_type s;
      if (idx < MOD_STEPS) begin
         s.shift    = SHIFT_W'(MOD_STEPS - 1 - idx);
         s.use_cols = 1'b0;
         s.capture  = 1'b0;
      end else begin
         s.shift    = SHIFT_W'(CELL_COUNT - 1 - idx);
         s.use_cols = 1'b1;
         s.capture  = (idx == MOD_STEPS);
      end
      return s;
   endfunction

endpackage

### design/cicc_front.sv
// ----------------------------------------------------------------------------
// cicc_front
// input register, products and range checks, divider operand setup
// ----------------------------------------------------------------------------
module cicc_front (
   input  logic                   clock,
   input  logic                   reset,
   input  cicc_pkg::cicc_cfg_type cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  cicc_pkg::cicc_req_type in_req,
   output logic                   out_valid,
   input  logic                   out_ready,
   output cicc_pkg::cicc_item_type out_item
);

   logic                    v0_ff, v0_in, v1_ff, v1_in, v2_ff, v2_in;
   logic                    rdy0, rdy1, rdy2;
   cicc_pkg::cicc_req_type  req_ff;
   cicc_pkg::cicc_mid_type  mid_ff, mid_in;
   cicc_pkg::cicc_item_type item_ff, item_in;

   logic [cicc_pkg::RC_W-1:0]    nr, nc;
   logic [cicc_pkg::PMOD_W-1:0]  unit_sel;
   logic [cicc_pkg::MOD_W-1:0]   mreq_m1;
   logic [cicc_pkg::RC_W-1:0]    row_m1;
   logic                         in_xtal;
   logic [cicc_pkg::ID_W-1:0]    z_pad;

   assign rdy2     = !v2_ff || out_ready;
   assign rdy1     = !v1_ff || rdy2;
   assign rdy0     = !v0_ff || rdy1;
   assign in_ready = rdy0;

   assign v0_in = rdy0 ? in_valid : v0_ff;
   assign v1_in = rdy1 ? v0_ff : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;

   // stage 1: products of the relative fields, grid checks
   always_comb begin
      nr       = req_ff.is_pad ? cfg.pad_rows : {1'b0, cfg.crystal_rows};
      nc       = req_ff.is_pad ? cfg.pad_cols : {1'b0, cfg.crystal_cols};
      unit_sel = req_ff.is_pad ? cfg.pad_mod : cicc_pkg::PMOD_W'(cfg.xtal_mod);
      mreq_m1  = req_ff.module_req - cicc_pkg::MOD_W'(1);
      row_m1   = req_ff.row - cicc_pkg::RC_W'(1);
      mid_in.opcode  = req_ff.opcode;
      mid_in.is_pad  = req_ff.is_pad;
      mid_in.zero_id = (req_ff.abs_id == '0);
      mid_in.z       = req_ff.abs_id - cicc_pkg::ID_W'(1);
      mid_in.column  = req_ff.column;
      mid_in.bad_rel = (req_ff.module_req == '0) || (req_ff.module_req > cfg.module_count)
                    || (req_ff.row == '0) || (req_ff.row > nr)
                    || (req_ff.column == '0) || (req_ff.column > nc);
      mid_in.mprod   = cicc_pkg::MPROD_W'(mreq_m1) * cicc_pkg::MPROD_W'(unit_sel);
      mid_in.rprod   = cicc_pkg::RPROD_W'(row_m1) * cicc_pkg::RPROD_W'(nc);
   end

   // stage 2: crystal or pad, dividend and divisors, partial sums
   always_comb begin
      in_xtal = mid_ff.z < cfg.xtal_all;
      z_pad   = mid_ff.z - cfg.xtal_all;
      item_in.opcode   = mid_ff.opcode;
      item_in.quot     = '0;
      item_in.quot_mod = '0;
      if (mid_ff.opcode == cicc_pkg::OP_TO_ABS) begin
         item_in.kind = mid_ff.is_pad;
         item_in.bad  = mid_ff.bad_rel;
      end else begin
         item_in.kind = !in_xtal;
         item_in.bad  = mid_ff.zero_id || (!in_xtal && (cfg.pad_mod == '0));
      end
      item_in.rem     = item_in.kind ? z_pad : mid_ff.z;
      item_in.per_mod = item_in.kind ? cfg.pad_mod : cicc_pkg::PMOD_W'(cfg.xtal_mod);
      item_in.cols    = item_in.kind ? cfg.pad_cols : {1'b0, cfg.crystal_cols};
      item_in.sum_hi  = (mid_ff.is_pad ? cicc_pkg::HI_W'(cfg.xtal_all) : '0)
                      + cicc_pkg::HI_W'(mid_ff.mprod);
      item_in.sum_lo  = cicc_pkg::LO_W'(mid_ff.rprod) + cicc_pkg::LO_W'(mid_ff.column);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && rdy0) begin
         req_ff <= in_req;
      end
      if (v0_ff && rdy1) begin
         mid_ff <= mid_in;
      end
      if (v1_ff && rdy2) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_item  = item_ff;

endmodule

### design/cicc_div_cell.sv
// ----------------------------------------------------------------------------
// cicc_div_cell
// one restoring division step: one quotient bit per cell, registered
// ----------------------------------------------------------------------------
module cicc_div_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  cicc_pkg::cicc_step_type step_cfg,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  cicc_pkg::cicc_item_type in_item,
   output logic                    out_valid,
   input  logic                    out_ready,
   output cicc_pkg::cicc_item_type out_item
);

   logic                    valid_ff, valid_in;
   cicc_pkg::cicc_item_type item_ff, item_in;

   logic [cicc_pkg::TRIAL_W-1:0] divisor, shifted, rem_wide, diff;
   logic                         fits;
   logic [cicc_pkg::RC_W-1:0]    quot_base;

   always_comb begin
      divisor   = step_cfg.use_cols ? cicc_pkg::TRIAL_W'(in_item.cols)
                                    : cicc_pkg::TRIAL_W'(in_item.per_mod);
      shifted   = divisor << step_cfg.shift;
      rem_wide  = cicc_pkg::TRIAL_W'(in_item.rem);
      fits      = rem_wide >= shifted;
      diff      = rem_wide - shifted;
      quot_base = step_cfg.capture ? '0 : in_item.quot;
      item_in   = in_item;
      // first row step keeps the module quotient and restarts
      if (step_cfg.capture) begin
         item_in.quot_mod = in_item.quot[cicc_pkg::MOD_STEPS-1:0];
      end
      item_in.quot = {quot_base[cicc_pkg::RC_W-2:0], fits};
      if (fits) begin
         item_in.rem = diff[cicc_pkg::ID_W-1:0];
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

### design/cicc_back.sv
// ----------------------------------------------------------------------------
// cicc_back
// final sum, range flags and output register
// ----------------------------------------------------------------------------
module cicc_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [cicc_pkg::MOD_W-1:0] module_count,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  cicc_pkg::cicc_item_type in_item,
   output logic                    out_valid,
   input  logic                    out_ready,
   output cicc_pkg::cicc_rsp_type  out_rsp
);

   logic                   valid_ff, valid_in;
   cicc_pkg::cicc_rsp_type rsp_ff, rsp_in;

   logic [cicc_pkg::SUM_W-1:0]  abs_sum;
   logic [cicc_pkg::MOD_W:0]    mod_num;
   logic                        bad;

   always_comb begin
      abs_sum = cicc_pkg::SUM_W'(in_item.sum_hi) + cicc_pkg::SUM_W'(in_item.sum_lo);
      mod_num = {1'b0, in_item.quot_mod[cicc_pkg::MOD_W-1:0]} + (cicc_pkg::MOD_W+1)'(1);
      rsp_in  = '0;
      if (in_item.opcode == cicc_pkg::OP_TO_ABS) begin
         bad = in_item.bad || (abs_sum > cicc_pkg::SUM_W'(cicc_pkg::ID_MAX));
         if (!bad) begin
            rsp_in.abs_id_out = abs_sum[cicc_pkg::ID_W-1:0];
         end
      end else begin
         // pad module past the last module in use
         bad = in_item.bad || (in_item.kind && (in_item.quot_mod[cicc_pkg::MOD_W]
               || (mod_num > {1'b0, module_count})));
         if (!bad) begin
            rsp_in.module_out = mod_num[cicc_pkg::MOD_W-1:0];
            rsp_in.is_pad_out = in_item.kind;
            rsp_in.row_out    = in_item.quot + cicc_pkg::RC_W'(1);
            rsp_in.column_out = in_item.rem[cicc_pkg::RC_W-1:0] + cicc_pkg::RC_W'(1);
         end
      end
      rsp_in.out_of_range = bad;
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

### design/calorimeter_cell_index_convert.sv
// ----------------------------------------------------------------------------
// calorimeter_cell_index_convert
// absolute cell id to module, kind, row, column and back, configurable grid
// ----------------------------------------------------------------------------
//
//   channel   dir   beat content
//   req_*     in    opcode, abs_id, module_req, is_pad, row, column
//   rsp_*     out   abs_id_out, module_out, is_pad_out, row_out, column_out,
//                   out_of_range
//   csr_*     in    register write: index 0..4, data up to 9 bits
//
// - one beat per clock in and out while rsp_tready stays high
// - depth is set by the divider chain: 14 cells, one quotient bit each
//   (5 for the module, 9 for the row), behind a 3-stage front end
// - each stage holds its beat and takes the next as soon as it moves on, so
//   a stalled rsp beat leaves room for new beats up to the pipeline depth
// - synchronous active-high reset empties the pipeline and loads the
//   default grid: 5 modules, 64x56 crystals, 128x60 veto pads
// ----------------------------------------------------------------------------
module calorimeter_cell_index_convert (
   input  logic                              clock,
   input  logic                              reset,
   // abs_id[19:0], module_req[23:20], row[32:24], column[41:33], zero fill
   input  logic [cicc_pkg::DATA_W-1:0]       req_tdata,
   // opcode[0], is_pad[1]
   input  logic [cicc_pkg::USER_W-1:0]       req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // abs_id_out[19:0], module_out[23:20], row_out[32:24], column_out[41:33]
   output logic [cicc_pkg::DATA_W-1:0]       rsp_tdata,
   // is_pad_out[0], out_of_range[1]
   output logic [cicc_pkg::USER_W-1:0]       rsp_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_wen,
   input  logic [cicc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cicc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // configuration registers
   logic [cicc_pkg::MOD_W-1:0]  module_count_ff, module_count_in;
   logic [cicc_pkg::XROW_W-1:0] crystal_rows_ff, crystal_rows_in;
   logic [cicc_pkg::XROW_W-1:0] crystal_cols_ff, crystal_cols_in;
   logic [cicc_pkg::RC_W-1:0]   pad_rows_ff, pad_rows_in;
   logic [cicc_pkg::RC_W-1:0]   pad_cols_ff, pad_cols_in;
   // grid products, one multiply per register
   logic [cicc_pkg::XMOD_W-1:0] xtal_mod_ff, xtal_mod_in;
   logic [cicc_pkg::PMOD_W-1:0] pad_mod_ff, pad_mod_in;
   logic [cicc_pkg::ID_W-1:0]   xtal_all_ff, xtal_all_in;

   cicc_pkg::cicc_cfg_type cfg;
   cicc_pkg::cicc_req_type req;
   cicc_pkg::cicc_rsp_type rsp;

   // links of the divider chain: 0 is the front end, CELL_COUNT the back end
   logic                    link_valid [cicc_pkg::CELL_COUNT+1];
   logic                    link_ready [cicc_pkg::CELL_COUNT+1];
   cicc_pkg::cicc_item_type link_item  [cicc_pkg::CELL_COUNT+1];

   // register writes, unknown indexes are dropped
   always_comb begin
      module_count_in = module_count_ff;
      crystal_rows_in = crystal_rows_ff;
      crystal_cols_in = crystal_cols_ff;
      pad_rows_in     = pad_rows_ff;
      pad_cols_in     = pad_cols_ff;
      if (csr_wen) begin
         unique case (csr_index)
            cicc_pkg::REG_MODULE_COUNT: module_count_in = csr_wdata[cicc_pkg::MOD_W-1:0];
            cicc_pkg::REG_CRYSTAL_ROWS: crystal_rows_in = csr_wdata[cicc_pkg::XROW_W-1:0];
            cicc_pkg::REG_CRYSTAL_COLS: crystal_cols_in = csr_wdata[cicc_pkg::XROW_W-1:0];
            cicc_pkg::REG_PAD_ROWS:     pad_rows_in     = csr_wdata;
            cicc_pkg::REG_PAD_COLS:     pad_cols_in     = csr_wdata;
            default: ;
         endcase
      end
   end

   // the products are registered, xtal_all from xtal_mod; the front end
   // reads xtal_all only in its third stage
   assign xtal_mod_in = cicc_pkg::XMOD_W'(crystal_rows_ff) * cicc_pkg::XMOD_W'(crystal_cols_ff);
   assign pad_mod_in  = cicc_pkg::PMOD_W'(pad_rows_ff) * cicc_pkg::PMOD_W'(pad_cols_ff);
   assign xtal_all_in = cicc_pkg::ID_W'(xtal_mod_ff) * cicc_pkg::ID_W'(module_count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         module_count_ff <= cicc_pkg::RST_MODULE_COUNT;
         crystal_rows_ff <= cicc_pkg::RST_CRYSTAL_ROWS;
         crystal_cols_ff <= cicc_pkg::RST_CRYSTAL_COLS;
         pad_rows_ff     <= cicc_pkg::RST_PAD_ROWS;
         pad_cols_ff     <= cicc_pkg::RST_PAD_COLS;
         xtal_mod_ff     <= cicc_pkg::RST_XTAL_MOD;
         pad_mod_ff      <= cicc_pkg::RST_PAD_MOD;
         xtal_all_ff     <= cicc_pkg::RST_XTAL_ALL;
      end else begin
         module_count_ff <= module_count_in;
         crystal_rows_ff <= crystal_rows_in;
         crystal_cols_ff <= crystal_cols_in;
         pad_rows_ff     <= pad_rows_in;
         pad_cols_ff     <= pad_cols_in;
         xtal_mod_ff     <= xtal_mod_in;
         pad_mod_ff      <= pad_mod_in;
         xtal_all_ff     <= xtal_all_in;
      end
   end

   always_comb begin
      cfg.module_count = module_count_ff;
      cfg.crystal_rows = crystal_rows_ff;
      cfg.crystal_cols = crystal_cols_ff;
      cfg.pad_rows     = pad_rows_ff;
      cfg.pad_cols     = pad_cols_ff;
      cfg.xtal_mod     = xtal_mod_ff;
      cfg.pad_mod      = pad_mod_ff;
      cfg.xtal_all     = xtal_all_ff;
   end

   // unpack the request beat
   always_comb begin
      req.opcode     = req_tuser[0];
      req.is_pad     = req_tuser[1];
      req.abs_id     = req_tdata[19:0];
      req.module_req = req_tdata[23:20];
      req.row        = req_tdata[32:24];
      req.column     = req_tdata[41:33];
   end

   cicc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_req    (req),
      .out_valid (link_valid[0]),
      .out_ready (link_ready[0]),
      .out_item  (link_item[0])
   );

   // module quotient cells first, then row quotient cells
   for (genvar i = 0; i < cicc_pkg::CELL_COUNT; i++) begin : g_cell
      cicc_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .step_cfg  (cicc_pkg::cell_step(i)),
         .in_valid  (link_valid[i]),
         .in_ready  (link_ready[i]),
         .in_item   (link_item[i]),
         .out_valid (link_valid[i+1]),
         .out_ready (link_ready[i+1]),
         .out_item  (link_item[i+1])
      );
   end

   cicc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .module_count (module_count_ff),
      .in_valid     (link_valid[cicc_pkg::CELL_COUNT]),
      .in_ready     (link_ready[cicc_pkg::CELL_COUNT]),
      .in_item      (link_item[cicc_pkg::CELL_COUNT]),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_rsp      (rsp)
   );

   // pack the result beat
   assign rsp_tdata = {6'b0, rsp.column_out, rsp.row_out, rsp.module_out, rsp.abs_id_out};
   assign rsp_tuser = {rsp.out_of_range, rsp.is_pad_out};

   // a flagged result carries nothing else
   a_flag_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> (rsp_tdata == '0) && !rsp_tuser[0])
      else $error("flagged result with nonzero fields");

   // a good result is either an absolute id or a relative position, never both
   a_one_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1]
      |-> (rsp_tdata[19:0] != '0) != (rsp_tdata[23:20] != '0))
      else $error("result is neither or both forms");

   // a good relative result has one-based row and column
   a_one_based: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] && (rsp_tdata[23:20] != '0)
      |-> (rsp_tdata[32:24] != '0) && (rsp_tdata[41:33] != '0))
      else $error("relative result with zero row or column");

   // a veto pad result only comes with a module number
   a_pad_module: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> (rsp_tdata[23:20] != '0))
      else $error("pad result without module");

endmodule

### bench/calorimeter_cell_index_convert_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calorimeter_cell_index_convert_test
// self-checking bench: cell id split and pack against a behavioral shadow
// ----------------------------------------------------------------------------
// a short table of hand-picked beats runs on the reset grid first, then
// random beats run on a series of grids: the widest register values, the
// smallest grid, the nominal upper grid, empty crystal and empty pad blocks,
// zero modules and a few random grids. each accepted request beat queues
// its typed answer or the shadow model's; each response beat is compared
// with the oldest queued answer; both throttle at random till the last third.
// ----------------------------------------------------------------------------
module calorimeter_cell_index_convert_test;

   // rough number of request beats, also paces the throttle modes
   localparam int BEATS_TARGET = 1900;
   // writes to the index range above the last register must be ignored
   localparam logic [cicc_pkg::CSR_IDX_W-1:0] REG_SPARE_LO = cicc_pkg::REG_PAD_COLS + 3'd1;
   // idle margin at the end of the run, after every answer is back
   localparam int TAIL_CYCLES = 40;

   // one row of the hand-written table: answer typed in or left to the shadow
   typedef struct packed {
      cicc_pkg::cicc_req_type req;
      logic                   typed;
      cicc_pkg::cicc_rsp_type want;
   } plan_row_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic [cicc_pkg::DATA_W-1:0]     req_tdata = '0;
   logic [cicc_pkg::USER_W-1:0]     req_tuser = '0;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [cicc_pkg::DATA_W-1:0]     rsp_tdata;
   logic [cicc_pkg::USER_W-1:0]     rsp_tuser;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic                            csr_wen = 1'b0;
   logic [cicc_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [cicc_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // shadow copy of the grid registers
   logic [cicc_pkg::MOD_W-1:0]  grid_modules = cicc_pkg::RST_MODULE_COUNT;
   logic [cicc_pkg::XROW_W-1:0] grid_xrows   = cicc_pkg::RST_CRYSTAL_ROWS;
   logic [cicc_pkg::XROW_W-1:0] grid_xcols   = cicc_pkg::RST_CRYSTAL_COLS;
   logic [cicc_pkg::RC_W-1:0]   grid_prows   = cicc_pkg::RST_PAD_ROWS;
   logic [cicc_pkg::RC_W-1:0]   grid_pcols   = cicc_pkg::RST_PAD_COLS;

   cicc_pkg::cicc_rsp_type expected_rsp [$];
   plan_row_type           plan [$];
   int                     fail_count = 0;
   int                     beats_sent = 0;
   int                     send_idle_pct = 0;
   int                     take_idle_pct = 0;

   calorimeter_cell_index_convert i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------------
   // shadow model
   // ------------------------------------------------------------------------

   // zero-based offset inside a block -> one-based module, row, column
   function automatic void split_index(input int unsigned z, input int unsigned per_row,
                                       input int unsigned per_mod, output int unsigned m,
                                       output int unsigned r, output int unsigned c);
      m = z / per_mod + 1;
      r = (z % per_mod) / per_row + 1;
      c = (z % per_mod) % per_row + 1;
   endfunction

   function automatic cicc_pkg::cicc_rsp_type convert_cell(cicc_pkg::cicc_req_type q);
      cicc_pkg::cicc_rsp_type o;
      int unsigned  xtal_mod, pad_mod, xtal_all, nr, nc, per_mod, base, v, m, r, c;
      logic         bad;
      o = '0;
      bad = 1'b0;
      m = 0;
      r = 0;
      c = 0;
      xtal_mod = grid_xrows * grid_xcols;
      pad_mod  = grid_prows * grid_pcols;
      xtal_all = xtal_mod * grid_modules;
      if (q.opcode == cicc_pkg::OP_TO_REL) begin
         if (q.abs_id == '0) begin
            bad = 1'b1;
         end else if (q.abs_id <= xtal_all) begin
            split_index(q.abs_id - 1, grid_xcols, xtal_mod, m, r, c);
         end else if (pad_mod == 0) begin
            // nothing past the crystals when the pad grid is empty
            bad = 1'b1;
         end else begin
            split_index(q.abs_id - xtal_all - 1, grid_pcols, pad_mod, m, r, c);
            o.is_pad_out = 1'b1;
            bad = (m > grid_modules);
         end
         if (bad) begin
            o.is_pad_out = 1'b0;
         end else begin
            o.module_out = cicc_pkg::MOD_W'(m);
            o.row_out    = cicc_pkg::RC_W'(r);
            o.column_out = cicc_pkg::RC_W'(c);
         end
      end else begin
         nr      = q.is_pad ? grid_prows : grid_xrows;
         nc      = q.is_pad ? grid_pcols : grid_xcols;
         per_mod = q.is_pad ? pad_mod : xtal_mod;
         base    = q.is_pad ? xtal_all : 0;
         if (q.module_req == 0 || q.module_req > grid_modules || q.row == 0 || q.row > nr ||
             q.column == 0 || q.column > nc) begin
            bad = 1'b1;
         end else begin
            v = base + (q.module_req - 1) * per_mod + (q.row - 1) * nc + q.column;
            // packed id has to fit the id field
            if (v > cicc_pkg::ID_MAX) bad = 1'b1;
            else o.abs_id_out = cicc_pkg::ID_W'(v);
         end
      end
      o.out_of_range = bad;
      return o;
   endfunction

   // ------------------------------------------------------------------------
   // table helpers
   // ------------------------------------------------------------------------

   function automatic cicc_pkg::cicc_req_type id_query(int unsigned id);
      cicc_pkg::cicc_req_type q;
      q = '0;
      q.opcode = cicc_pkg::OP_TO_REL;
      q.abs_id = cicc_pkg::ID_W'(id);
      return q;
   endfunction

   function automatic cicc_pkg::cicc_req_type cell_query(int unsigned m, logic pad,
                                                         int unsigned r, int unsigned c);
      cicc_pkg::cicc_req_type q;
      q = '0;
      q.opcode     = cicc_pkg::OP_TO_ABS;
      q.module_req = cicc_pkg::MOD_W'(m);
      q.is_pad     = pad;
      q.row        = cicc_pkg::RC_W'(r);
      q.column     = cicc_pkg::RC_W'(c);
      return q;
   endfunction

   function automatic cicc_pkg::cicc_rsp_type cell_answer(int unsigned m, logic pad,
                                                          int unsigned r, int unsigned c);
      cicc_pkg::cicc_rsp_type o;
      o = '0;
      o.module_out = cicc_pkg::MOD_W'(m);
      o.is_pad_out = pad;
      o.row_out    = cicc_pkg::RC_W'(r);
      o.column_out = cicc_pkg::RC_W'(c);
      return o;
   endfunction

   function automatic cicc_pkg::cicc_rsp_type id_answer(int unsigned id);
      cicc_pkg::cicc_rsp_type o;
      o = '0;
      o.abs_id_out = cicc_pkg::ID_W'(id);
      return o;
   endfunction

   function automatic cicc_pkg::cicc_rsp_type flagged();
      cicc_pkg::cicc_rsp_type o;
      o = '0;
      o.out_of_range = 1'b1;
      return o;
   endfunction

   task automatic add_checked(cicc_pkg::cicc_req_type q, cicc_pkg::cicc_rsp_type want);
      plan_row_type p;
      p.req   = q;
      p.typed = 1'b1;
      p.want  = want;
      plan.push_back(p);
   endtask

   task automatic add_predicted(cicc_pkg::cicc_req_type q);
      plan_row_type p;
      p.req   = q;
      p.typed = 1'b0;
      p.want  = '0;
      plan.push_back(p);
   endtask

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------

   // one request beat; tvalid stays high on return so beats can go back to back
   task automatic push_request(cicc_pkg::cicc_req_type q, logic typed,
                               cicc_pkg::cicc_rsp_type want);
      // throttle modes: slow receiver, then slow sender, then full rate
      if (beats_sent < BEATS_TARGET / 3) begin
         send_idle_pct = 26;
         take_idle_pct = 68;
      end else if (beats_sent < 2 * BEATS_TARGET / 3) begin
         send_idle_pct = 68;
         take_idle_pct = 26;
      end else begin
         send_idle_pct = 0;
         take_idle_pct = 0;
      end
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      // zero fill, column, row, module_req, abs_id from the top bits down
      req_tdata  <= {{(cicc_pkg::DATA_W - 42){1'b0}}, q.column, q.row, q.module_req,
                     q.abs_id};
      req_tuser  <= {q.is_pad, q.opcode};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_rsp.push_back(typed ? want : convert_cell(q));
      beats_sent++;
   endtask

   // drop tvalid and hold off until every answer is back
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
   endtask

   // register write; unused high data bits carry noise that must be dropped
   task automatic write_reg(logic [cicc_pkg::CSR_IDX_W-1:0] idx, int unsigned val);
      logic [cicc_pkg::CSR_DATA_W-1:0] noise, data;
      noise = cicc_pkg::CSR_DATA_W'($urandom);
      case (idx)
         cicc_pkg::REG_MODULE_COUNT: begin
            data = {noise[8:4], val[3:0]};
            grid_modules = val[3:0];
         end
         cicc_pkg::REG_CRYSTAL_ROWS: begin
            data = {noise[8], val[7:0]};
            grid_xrows = val[7:0];
         end
         cicc_pkg::REG_CRYSTAL_COLS: begin
            data = {noise[8], val[7:0]};
            grid_xcols = val[7:0];
         end
         cicc_pkg::REG_PAD_ROWS: begin
            data = val[8:0];
            grid_prows = val[8:0];
         end
         cicc_pkg::REG_PAD_COLS: begin
            data = val[8:0];
            grid_pcols = val[8:0];
         end
         default: begin
            data = noise;
         end
      endcase
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // new grid, written only with the pipeline empty
   task automatic apply_grid(int unsigned mods, int unsigned xr, int unsigned xc,
                             int unsigned pr, int unsigned pc);
      settle();
      write_reg(REG_SPARE_LO + 3'($urandom_range(0, 2)), 0);
      write_reg(cicc_pkg::REG_MODULE_COUNT, mods);
      write_reg(cicc_pkg::REG_CRYSTAL_ROWS, xr);
      write_reg(cicc_pkg::REG_CRYSTAL_COLS, xc);
      write_reg(cicc_pkg::REG_PAD_ROWS, pr);
      write_reg(cicc_pkg::REG_PAD_COLS, pc);
      csr_wen <= 1'b0;
   endtask

   // random beat shaped by the current grid: mostly legal ids and cells,
   // with edges, zero, overflow and full noise mixed in
   function automatic cicc_pkg::cicc_req_type random_request();
      cicc_pkg::cicc_req_type q;
      int unsigned  xtal_all, pad_all, nr, nc, v, pick;
      // unused fields of each opcode carry noise
      q.abs_id     = cicc_pkg::ID_W'($urandom);
      q.module_req = cicc_pkg::MOD_W'($urandom);
      q.is_pad     = 1'($urandom);
      q.row        = cicc_pkg::RC_W'($urandom);
      q.column     = cicc_pkg::RC_W'($urandom);
      q.opcode     = $urandom_range(0, 1) ? cicc_pkg::OP_TO_ABS : cicc_pkg::OP_TO_REL;
      xtal_all = grid_modules * grid_xrows * grid_xcols;
      pad_all  = grid_modules * grid_prows * grid_pcols;
      pick     = $urandom_range(0, 19);
      if (q.opcode == cicc_pkg::OP_TO_REL) begin
         v = q.abs_id;
         if (pick == 0) v = 0;
         else if (pick < 9) v = $urandom_range(1, xtal_all);
         else if (pick < 16) v = xtal_all + $urandom_range(1, pad_all + 2);
         else if (pick == 16) v = xtal_all + $urandom_range(0, 1);
         else if (pick == 17) v = xtal_all + pad_all + $urandom_range(0, 1);
         // past the id field: land somewhere in the upper id range instead
         if (v > cicc_pkg::ID_MAX) v = $urandom_range(xtal_all + 1, cicc_pkg::ID_MAX);
         q.abs_id = cicc_pkg::ID_W'(v);
      end else begin
         nr = q.is_pad ? grid_prows : grid_xrows;
         nc = q.is_pad ? grid_pcols : grid_xcols;
         q.module_req = cicc_pkg::MOD_W'($urandom_range(1, grid_modules));
         q.row        = cicc_pkg::RC_W'($urandom_range(1, nr));
         q.column     = cicc_pkg::RC_W'($urandom_range(1, nc));
         case (pick)
            0: q.module_req = cicc_pkg::MOD_W'($urandom);
            1: q.row = cicc_pkg::RC_W'($urandom);
            2: q.column = cicc_pkg::RC_W'($urandom);
            3: begin
               q.module_req = grid_modules;
               q.row        = cicc_pkg::RC_W'(nr);
               q.column     = cicc_pkg::RC_W'(nc);
            end
            4: q.row = cicc_pkg::RC_W'(nr + 1);
            5: q.column = cicc_pkg::RC_W'(nc + 1);
            6: q.module_req = cicc_pkg::MOD_W'(grid_modules + 1);
            default: ;
         endcase
      end
      return q;
   endfunction

   task automatic random_batch(int count);
      for (int k = 0; k < count; k++) begin
         push_request(random_request(), 1'b0, '0);
         // now and then let the pipeline run dry before going on
         if (k % 97 == 96) settle();
      end
   endtask

   // ------------------------------------------------------------------------
   // response side
   // ------------------------------------------------------------------------

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= take_idle_pct);
   end

   task automatic report_beat(string what, cicc_pkg::cicc_rsp_type got,
                              cicc_pkg::cicc_rsp_type want);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t %s: got id %0d mod %0d pad %0d row %0d col %0d oor %0d", $time, what,
                  got.abs_id_out, got.module_out, got.is_pad_out, got.row_out,
                  got.column_out, got.out_of_range);
         $display("   expected id %0d mod %0d pad %0d row %0d col %0d oor %0d",
                  want.abs_id_out, want.module_out, want.is_pad_out, want.row_out,
                  want.column_out, want.out_of_range);
      end
   endtask

   always @(posedge clock) begin : rsp_check
      cicc_pkg::cicc_rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.abs_id_out   = rsp_tdata[19:0];
         got.module_out   = rsp_tdata[23:20];
         got.row_out      = rsp_tdata[32:24];
         got.column_out   = rsp_tdata[41:33];
         got.is_pad_out   = rsp_tuser[0];
         got.out_of_range = rsp_tuser[1];
         if (expected_rsp.size() == 0) begin
            report_beat("unexpected response beat", got, '0);
         end else begin
            want = expected_rsp.pop_front();
            if (got !== want) report_beat("response mismatch", got, want);
         end
      end
   end

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------

   initial begin : stimulus
      cicc_pkg::cicc_req_type q;

      // reset grid: 5 modules, 17920 crystals, pads 17921..56320
      add_checked(id_query(0), flagged());                         // zero id
      add_checked(id_query(1), cell_answer(1, 1'b0, 1, 1));
      add_checked(id_query(56), cell_answer(1, 1'b0, 1, 56));      // end of first row
      add_checked(id_query(57), cell_answer(1, 1'b0, 2, 1));
      add_checked(id_query(3584), cell_answer(1, 1'b0, 64, 56));   // end of module 1
      add_checked(id_query(3585), cell_answer(2, 1'b0, 1, 1));
      add_checked(id_query(17920), cell_answer(5, 1'b0, 64, 56));  // last crystal
      add_checked(id_query(17921), cell_answer(1, 1'b1, 1, 1));    // first pad
      add_checked(id_query(56320), cell_answer(5, 1'b1, 128, 60)); // last pad
      add_checked(id_query(56321), flagged());                     // past all pads
      add_checked(id_query(cicc_pkg::ID_MAX), flagged());
      // split with every unused field at all ones
      q = id_query(1000);
      q.module_req = '1;
      q.is_pad     = 1'b1;
      q.row        = '1;
      q.column     = '1;
      add_predicted(q);
      add_checked(cell_query(1, 1'b0, 1, 1), id_answer(1));
      add_checked(cell_query(5, 1'b0, 64, 56), id_answer(17920));
      add_checked(cell_query(1, 1'b1, 1, 1), id_answer(17921));
      add_checked(cell_query(5, 1'b1, 128, 60), id_answer(56320));
      // bad relative fields
      add_checked(cell_query(0, 1'b0, 1, 1), flagged());
      add_checked(cell_query(6, 1'b0, 1, 1), flagged());
      add_checked(cell_query(15, 1'b1, 511, 511), flagged());
      add_checked(cell_query(1, 1'b0, 0, 1), flagged());
      add_checked(cell_query(1, 1'b0, 65, 1), flagged());
      add_checked(cell_query(1, 1'b0, 1, 57), flagged());
      add_checked(cell_query(1, 1'b1, 129, 1), flagged());
      add_checked(cell_query(1, 1'b1, 1, 0), flagged());
      // pack with the unused id field at all ones
      q = cell_query(3, 1'b1, 100, 30);
      q.abs_id = cicc_pkg::ID_MAX;
      add_predicted(q);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) push_request(plan[i].req, plan[i].typed, plan[i].want);
      random_batch(300);

      // widest register values, packed ids overflow the id field
      apply_grid(15, 255, 255, 511, 511);
      random_batch(200);
      // smallest legal grid
      apply_grid(1, 1, 1, 1, 1);
      random_batch(150);
      // top of the nominal range
      apply_grid(8, 128, 128, 256, 256);
      random_batch(200);
      // empty crystal block, every id is a pad
      apply_grid(4, 0, 9, 3, 5);
      random_batch(120);
      // empty pad block
      apply_grid(3, 5, 7, 6, 0);
      random_batch(120);
      // no modules at all
      apply_grid(0, 4, 4, 4, 4);
      random_batch(80);
      // small random grids keep the id space dense
      for (int g = 0; g < 6; g++) begin
         apply_grid($urandom_range(1, 8), $urandom_range(1, 16), $urandom_range(1, 16),
                    $urandom_range(1, 32), $urandom_range(1, 32));
         random_batch(120);
      end

      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_rsp.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin : watchdog
      #1_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
